@@ rtl/spq_pkg.sv @@
// Shared definitions for the sorted priority queue.
// Holds operation and status codes, the controller state type and default sizes.
// Depends on nothing; the controller, the top level and the checker import it.
package spq_pkg;

	// Default sizes handed to the top level parameters.
	localparam int SPQ_DEPTH          = 16;
	localparam int SPQ_VALUE_WIDTH    = 32;
	localparam int SPQ_PRIORITY_WIDTH = 8;

	// Operation codes carried by an input transaction.
	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_CLEAR   = 2'd2
	} spq_op_t;

	// Status codes reported with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	// Controller sequencing states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HEAD,
		S_DONE
	} spq_state_t;

endpackage

@@ rtl/spq_ram.sv @@
// Entry storage of the sorted priority queue: one write port, one read port.
// Read data is registered, so it appears in the cycle after the read request.
// Depends on spq_pkg only by convention of the project; no package items are needed.
module spq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 40,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/spq_ctrl.sv @@
// Sequencer of the sorted priority queue: decodes a transaction, walks the
// stored entries through the entry memory and builds the result.
// Depends on spq_pkg and drives the ports of spq_ram.
module spq_ctrl #(
	parameter int DEPTH          = 16,
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 8,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int EW = PRIORITY_WIDTH + VALUE_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input transaction.
	input  logic                      in_valid,
	output logic                      in_ready,
	input  spq_pkg::spq_op_t          operation,
	input  logic [VALUE_WIDTH-1:0]    value_in,
	input  logic [PRIORITY_WIDTH-1:0] priority_in,
	// Entry memory.
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [EW-1:0]             mem_wdata,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	input  logic [EW-1:0]             mem_rdata,
	// Result toward the output register.
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [VALUE_WIDTH-1:0]    res_value,
	output logic [VALUE_WIDTH-1:0]    res_head,
	output logic [CW-1:0]             res_count,
	output spq_pkg::spq_status_t      res_status
);
	import spq_pkg::*;

	spq_state_t                state_q, state_n;
	logic [CW-1:0]             count_q, count_n;
	logic [AW-1:0]             head_ptr_q, head_ptr_n;
	logic [VALUE_WIDTH-1:0]    head_val_q, head_val_n;
	logic [PRIORITY_WIDTH-1:0] head_pri_q, head_pri_n;
	logic [VALUE_WIDTH-1:0]    val_q, val_n;
	logic [PRIORITY_WIDTH-1:0] pri_q, pri_n;
	logic [CW-1:0]             k_q, k_n;
	spq_status_t               status_q, status_n;
	logic [VALUE_WIDTH-1:0]    removed_q, removed_n;

	logic [PRIORITY_WIDTH-1:0] rd_pri;
	logic [VALUE_WIDTH-1:0]    rd_val;
	logic [AW-1:0]             head_dec;

	// Physical address of a logical position; the entries form a ring from the head.
	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off[AW-1:0]};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_pri   = mem_rdata[EW-1 -: PRIORITY_WIDTH];
	assign rd_val   = mem_rdata[VALUE_WIDTH-1:0];
	assign head_dec = (head_ptr_q == '0) ? AW'(DEPTH - 1) : head_ptr_q - AW'(1);

	// State and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			head_ptr_q <= '0;
		end else begin
			state_q    <= state_n;
			count_q    <= count_n;
			head_ptr_q <= head_ptr_n;
		end
	end

	always_ff @(posedge clk) begin
		head_val_q <= head_val_n;
		head_pri_q <= head_pri_n;
		val_q      <= val_n;
		pri_q      <= pri_n;
		k_q        <= k_n;
		status_q   <= status_n;
		removed_q  <= removed_n;
	end

	// Next state, memory requests and handshakes. Every write lands before any later
	// read of the same entry, so no forwarding is needed.
	always_comb begin
		state_n    = state_q;
		count_n    = count_q;
		head_ptr_n = head_ptr_q;
		head_val_n = head_val_q;
		head_pri_n = head_pri_q;
		val_n      = val_q;
		pri_n      = pri_q;
		k_n        = k_q;
		status_n   = status_q;
		removed_n  = removed_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = {pri_q, val_q};
		mem_re     = 1'b0;
		mem_raddr  = '0;
		in_ready   = 1'b0;
		res_valid  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					status_n  = ST_OK;
					removed_n = '0;
					state_n   = S_DONE;
					unique case (operation)
						OP_ENQUEUE: begin
							val_n = value_in;
							pri_n = priority_in;
							if (count_q == CW'(DEPTH)) begin
								status_n = ST_FULL;
							end else if (count_q == '0 || priority_in < head_pri_q) begin
								// New head: step the ring start back instead of shifting.
								mem_we     = 1'b1;
								mem_waddr  = head_dec;
								mem_wdata  = {priority_in, value_in};
								head_ptr_n = head_dec;
								head_val_n = value_in;
								head_pri_n = priority_in;
								count_n    = count_q + CW'(1);
							end else begin
								// Walk back from the tail, moving entries up one slot.
								mem_re    = 1'b1;
								mem_raddr = ring_addr(head_ptr_q, count_q - CW'(1));
								k_n       = count_q;
								state_n   = S_SCAN;
							end
						end
						OP_DEQUEUE: begin
							if (count_q == '0) begin
								status_n = ST_EMPTY;
							end else begin
								removed_n  = head_val_q;
								head_ptr_n = ring_addr(head_ptr_q, CW'(1));
								count_n    = count_q - CW'(1);
								if (count_q != CW'(1)) begin
									mem_re    = 1'b1;
									mem_raddr = ring_addr(head_ptr_q, CW'(1));
									state_n   = S_HEAD;
								end
							end
						end
						OP_CLEAR: begin
							count_n = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				// Read data holds the entry at logical position k - 1.
				mem_we    = 1'b1;
				mem_waddr = ring_addr(head_ptr_q, k_q);
				if (k_q >= CW'(2) && rd_pri >= pri_q) begin
					mem_wdata = mem_rdata;
					k_n       = k_q - CW'(1);
					mem_re    = 1'b1;
					mem_raddr = ring_addr(head_ptr_q, k_q - CW'(2));
				end else begin
					count_n = count_q + CW'(1);
					state_n = S_DONE;
				end
			end
			S_HEAD: begin
				// Capture the new head after a dequeue.
				head_val_n = rd_val;
				head_pri_n = rd_pri;
				state_n    = S_DONE;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Result fields.
	assign res_value  = removed_q;
	assign res_head   = (count_q != '0) ? head_val_q : '0;
	assign res_count  = count_q;
	assign res_status = status_q;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue: up to DEPTH value/priority entries, lowest priority served first.
// Input channel in_valid/in_ready carries operation, value_in and priority_in; one
// transaction is enqueue, dequeue or clear. Output channel out_valid/out_ready returns
// exactly one result per transaction: removed value, head value, count, empty flag, status.
// Entries live in a ring inside one memory with a registered read; a dequeue just moves
// the ring start and an enqueue ahead of the head steps it back.
// A clear, a refused operation, an enqueue at the head and a dequeue that leaves the queue
// empty go straight to the result; another dequeue first reads the new head, and an
// enqueue behind the head first moves the entries that come after it up one slot, one
// per cycle through the memory port.
// One transaction is in work at a time; the next is accepted once the result has moved
// into the output register. If the receiver stalls, the result waits in the output
// register and the controller holds its finished result, accepting nothing more until
// the register frees.
// Reset clears the count, the ring start and both valids; memory contents stay undefined.
// Depends on spq_pkg, spq_ram and spq_ctrl.
module sorted_priority_queue #(
	parameter int DEPTH          = spq_pkg::SPQ_DEPTH,
	parameter int VALUE_WIDTH    = spq_pkg::SPQ_VALUE_WIDTH,
	parameter int PRIORITY_WIDTH = spq_pkg::SPQ_PRIORITY_WIDTH,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  spq_pkg::spq_op_t          operation,
	input  logic [VALUE_WIDTH-1:0]    value_in,
	input  logic [PRIORITY_WIDTH-1:0] priority_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [VALUE_WIDTH-1:0]    value_out,
	output logic [VALUE_WIDTH-1:0]    head_value,
	output logic [CW-1:0]             entry_count,
	output logic                      queue_empty,
	output spq_pkg::spq_status_t      status
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int EW = PRIORITY_WIDTH + VALUE_WIDTH;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [EW-1:0]          mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [EW-1:0]          mem_rdata;
	logic                   res_valid;
	logic                   res_ready;
	logic [VALUE_WIDTH-1:0] res_value;
	logic [VALUE_WIDTH-1:0] res_head;
	logic [CW-1:0]          res_count;
	spq_status_t            res_status;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] value_out_q;
	logic [VALUE_WIDTH-1:0] head_value_q;
	logic [CW-1:0]          entry_count_q;
	logic                   queue_empty_q;
	spq_status_t            status_q;

	spq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	spq_ctrl #(
		.DEPTH          (DEPTH),
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.value_in    (value_in),
		.priority_in (priority_in),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_value   (res_value),
		.res_head    (res_head),
		.res_count   (res_count),
		.res_status  (res_status)
	);

	// The output register takes a result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			value_out_q   <= res_value;
			head_value_q  <= res_head;
			entry_count_q <= res_count;
			queue_empty_q <= (res_count == '0);
			status_q      <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_out   = value_out_q;
	assign head_value  = head_value_q;
	assign entry_count = entry_count_q;
	assign queue_empty = queue_empty_q;
	assign status      = status_q;

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg for the status codes.
module spq_checker #(
	parameter int DEPTH          = spq_pkg::SPQ_DEPTH,
	parameter int VALUE_WIDTH    = spq_pkg::SPQ_VALUE_WIDTH,
	parameter int PRIORITY_WIDTH = spq_pkg::SPQ_PRIORITY_WIDTH,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input spq_pkg::spq_op_t          operation,
	input logic [VALUE_WIDTH-1:0]    value_in,
	input logic [PRIORITY_WIDTH-1:0] priority_in,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [VALUE_WIDTH-1:0]    value_out,
	input logic [VALUE_WIDTH-1:0]    head_value,
	input logic [CW-1:0]             entry_count,
	input logic                      queue_empty,
	input spq_pkg::spq_status_t      status
);
	import spq_pkg::*;

	// A waiting input transaction keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(value_in) &&
			$stable(priority_in))
		else $error("input transaction changed while waiting");

	// A stalled result holds its value and count.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(entry_count))
		else $error("result changed while stalled");

	// The empty flag, the count and the head value agree.
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queue_empty == (entry_count == '0)) &&
			(!queue_empty || head_value == '0))
		else $error("empty flag, count and head value disagree");

	// A refused enqueue is only reported on a full queue.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == CW'(DEPTH) && value_out == '0)
		else $error("full refusal with room left");

	// A refused dequeue is only reported on an empty queue.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> queue_empty && value_out == '0)
		else $error("empty refusal on a filled queue");

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH          (DEPTH),
	.VALUE_WIDTH    (VALUE_WIDTH),
	.PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_spq_checker (.*);
